// ===== rtl/itp_pkg.sv =====
// Package for the integer text parser: character codes, phase and radix types.
// Used by rtl/integer_text_parser_unit.sv; depends on nothing.
package itp_pkg;

    localparam int CharWidth  = 16;
    localparam int ValueWidth = 64;
    localparam int IndexWidth = 16;

    localparam logic [CharWidth-1:0] CHAR_SPACE   = 16'h0020;
    localparam logic [CharWidth-1:0] CHAR_TAB     = 16'h0009;
    localparam logic [CharWidth-1:0] CHAR_CR      = 16'h000D;
    localparam logic [CharWidth-1:0] CHAR_PLUS    = 16'h002B;
    localparam logic [CharWidth-1:0] CHAR_MINUS   = 16'h002D;
    localparam logic [CharWidth-1:0] CHAR_PERCENT = 16'h0025;
    localparam logic [CharWidth-1:0] CHAR_DOLLAR  = 16'h0024;
    localparam logic [CharWidth-1:0] CHAR_ZERO    = 16'h0030;
    localparam logic [CharWidth-1:0] CHAR_NINE    = 16'h0039;
    localparam logic [CharWidth-1:0] CHAR_UPPER_A = 16'h0041;
    localparam logic [CharWidth-1:0] CHAR_UPPER_F = 16'h0046;
    localparam logic [CharWidth-1:0] CHAR_LOWER_A = 16'h0061;
    localparam logic [CharWidth-1:0] CHAR_LOWER_F = 16'h0066;

    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_TAIL   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    function automatic logic is_space(input logic [CharWidth-1:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

// ===== rtl/integer_text_parser_unit.sv =====
// Top level of the integer text parser: input register, parse logic, result register.
// Depends on rtl/itp_pkg.sv.
// Output: out_valid rises when the last item of a string moves from the input register into the result register.
// Throughput: one item per cycle, but the last item of a string waits while a result is held and out_ready is low;
// the digit step (multiply by base and add) is combinational. Reset: rst_n clears the parse state, the strict mode
// bit and both valid flags. No memory, so there is no clearing pass after reset.
module integer_text_parser_unit #(
    parameter int MAX_CHARS = 65535
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic                             cfg_write_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [itp_pkg::CharWidth-1:0]    char_code,
    input  logic                             last_char,
    input  logic                             empty_string,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [itp_pkg::ValueWidth-1:0]   value,
    output logic [itp_pkg::IndexWidth-1:0]   stop_index
);
    import itp_pkg::*;

    localparam logic [IndexWidth-1:0] PosCap =
        (MAX_CHARS < 65535) ? IndexWidth'(MAX_CHARS) : {IndexWidth{1'b1}};

    logic                  strict_reg;
    logic                  s1_valid_reg;
    logic [CharWidth-1:0]  s1_char_reg;
    logic                  s1_last_reg;
    logic                  s1_empty_reg;

    phase_t                phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    radix_t                radix_reg, radix_next;
    logic [ValueWidth-1:0] acc_reg, acc_next;
    logic [IndexWidth-1:0] pos_reg, pos_next;
    logic [IndexWidth-1:0] stop_reg, stop_next;
    logic                  clean_reg, clean_next;

    logic                  out_valid_reg;
    logic [ValueWidth-1:0] value_reg;
    logic [IndexWidth-1:0] stop_index_reg;

    logic                  ends;
    logic                  s1_fire;
    logic                  do_digit;
    logic                  c_space;
    logic [3:0]            digit;
    logic                  digit_ok;
    logic [ValueWidth-1:0] acc_step;
    logic [ValueWidth-1:0] res_value;
    logic [IndexWidth-1:0] res_stop;

    assign ends     = s1_last_reg || s1_empty_reg;
    assign s1_fire  = s1_valid_reg && !(ends && out_valid_reg && !out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign stop_index = stop_index_reg;

    assign c_space = is_space(s1_char_reg);

    always_comb
    begin
        digit    = 4'd0;
        digit_ok = 1'b0;
        if (s1_char_reg >= CHAR_ZERO && s1_char_reg <= CHAR_NINE)
        begin
            digit    = 4'(s1_char_reg - CHAR_ZERO);
            digit_ok = (radix_reg != RADIX_BIN) || (digit < 4'd2);
        end
        else if (s1_char_reg >= CHAR_UPPER_A && s1_char_reg <= CHAR_UPPER_F)
        begin
            digit    = 4'(s1_char_reg - CHAR_UPPER_A + 16'd10);
            digit_ok = (radix_reg == RADIX_HEX);
        end
        else if (s1_char_reg >= CHAR_LOWER_A && s1_char_reg <= CHAR_LOWER_F)
        begin
            digit    = 4'(s1_char_reg - CHAR_LOWER_A + 16'd10);
            digit_ok = (radix_reg == RADIX_HEX);
        end
    end

    always_comb
    begin
        unique case (radix_reg)
            RADIX_BIN: acc_step = {acc_reg[ValueWidth-2:0], 1'b0} | ValueWidth'(digit);
            RADIX_HEX: acc_step = {acc_reg[ValueWidth-5:0], 4'b0000} | ValueWidth'(digit);
            default:   acc_step = {acc_reg[ValueWidth-4:0], 3'b000}
                                  + {acc_reg[ValueWidth-2:0], 1'b0} + ValueWidth'(digit);
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        stop_next  = stop_reg;
        clean_next = clean_reg;
        do_digit   = 1'b0;
        if (!s1_empty_reg)
        begin
            unique case (phase_reg)
                PH_SPACE:
                begin
                    if (!c_space)
                    begin
                        if (s1_char_reg == CHAR_PLUS)
                        begin
                            phase_next = PH_PREFIX;
                        end
                        else if (s1_char_reg == CHAR_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_PREFIX;
                        end
                        else
                        begin
                            phase_next = PH_DIGITS;
                            if (s1_char_reg == CHAR_PERCENT)
                                radix_next = RADIX_BIN;
                            else if (s1_char_reg == CHAR_DOLLAR)
                                radix_next = RADIX_HEX;
                            else
                                do_digit = 1'b1;
                        end
                    end
                end
                PH_PREFIX:
                begin
                    phase_next = PH_DIGITS;
                    if (s1_char_reg == CHAR_PERCENT)
                        radix_next = RADIX_BIN;
                    else if (s1_char_reg == CHAR_DOLLAR)
                        radix_next = RADIX_HEX;
                    else
                        do_digit = 1'b1;
                end
                PH_DIGITS:
                begin
                    do_digit = 1'b1;
                end
                default:
                begin
                    if (!c_space)
                        clean_next = 1'b0;
                end
            endcase
            if (do_digit)
            begin
                if (digit_ok)
                begin
                    acc_next = acc_step;
                end
                else
                begin
                    stop_next  = pos_reg;
                    phase_next = PH_TAIL;
                    if (!c_space)
                        clean_next = 1'b0;
                end
            end
            if (pos_reg < PosCap)
                pos_next = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_stop  = (phase_next == PH_TAIL) ? stop_next : pos_next;
        res_value = neg_next ? (ValueWidth'(0) - acc_next) : acc_next;
        if (strict_reg && !clean_next)
            res_value = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            radix_reg     <= RADIX_DEC;
            acc_reg       <= '0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            clean_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_write_en)
                strict_reg <= cfg_write_data;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_fire && ends)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (s1_fire)
            begin
                if (ends)
                begin
                    phase_reg <= PH_SPACE;
                    neg_reg   <= 1'b0;
                    radix_reg <= RADIX_DEC;
                    acc_reg   <= '0;
                    pos_reg   <= '0;
                    stop_reg  <= '0;
                    clean_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    radix_reg <= radix_next;
                    acc_reg   <= acc_next;
                    pos_reg   <= pos_next;
                    stop_reg  <= stop_next;
                    clean_reg <= clean_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg  <= char_code;
            s1_last_reg  <= last_char;
            s1_empty_reg <= empty_string;
        end
        if (s1_fire && ends)
        begin
            value_reg      <= res_value;
            stop_index_reg <= res_stop;
        end
    end

endmodule
